### design/gctg_pkg.sv
// ----------------------------------------------------------------------------
// gctg_pkg: shared types, constants and helpers of the grid-cell texel generator
// Fixed-point formats, palette, strip constants and pipeline stage map.
// ----------------------------------------------------------------------------
`default_nettype none

package gctg_pkg;

  // Geometry and formats
  localparam int unsigned MAX_SIZE_LOG2_DEF = 10;
  localparam int unsigned CFG_SIZE_W        = 4;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 4;
  localparam int unsigned POS_W             = 16;   // Q0.16 position
  localparam int unsigned FAC_W             = 17;   // Q0.16 factor, up to 1.0
  localparam int unsigned CHAN_W            = 16;   // Q0.16 color channel
  localparam int unsigned BYTE_W            = 8;

  // Pipeline stage map
  localparam int unsigned NUM_STAGES = 9;
  localparam int unsigned STG_COORD  = 0;   // two stages
  localparam int unsigned STG_FACTOR = 2;   // four stages
  localparam int unsigned STG_SHADE  = 6;   // three stages
  localparam int unsigned COORD_STG_N  = 2;
  localparam int unsigned FACTOR_STG_N = 4;
  localparam int unsigned SHADE_STG_N  = 3;

  localparam logic [CFG_SIZE_W-1:0] SIZE_LOG2_RST  = 4'd10;
  localparam logic [CFG_SIZE_W-1:0] THICK_MIN_LOG2 = 4'd5;   // side above 16
  localparam logic [CFG_SIZE_W-1:0] THIN_MIN_LOG2  = 4'd7;   // side above 64

  localparam logic [POS_W-1:0] HALF_POS = 16'h8000;
  localparam logic [FAC_W-1:0] ONE_Q16  = 17'h10000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_LOG2   = 1'b0,
    REG_THIN_ENABLE = 1'b1
  } cfg_reg_t;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  // Palette in Q0.16
  localparam rgb_t BG_COLOR    = '{r: 16'd13107, g: 16'd0,     b: 16'd26214};
  localparam rgb_t THICK_COLOR = '{r: 16'd39322, g: 16'd26214, b: 16'd52429};
  localparam rgb_t THIN_COLOR  = '{r: 16'd19661, g: 16'd13107, b: 16'd32768};

  // Strip constants. A strip starts at distance D_MIN; the factor is
  // floor((20000*D - N_OFF) * RCP >> RCP_SHIFT), an exact reciprocal divide
  // by twice the falloff with half-up rounding folded into N_OFF.
  localparam int unsigned THICK_D_MIN     = 32244;
  localparam int unsigned THICK_N_OFF     = 644218805;
  localparam int unsigned THICK_RCP       = 28633116;
  localparam int unsigned THICK_RCP_SHIFT = 32;
  localparam int unsigned THICK_N_W       = 24;
  localparam int unsigned THICK_RCP_W     = 25;

  localparam int unsigned THIN_D_MIN      = 29328;
  localparam int unsigned THIN_N_OFF      = 583269900;
  localparam int unsigned THIN_RCP        = 68719477;
  localparam int unsigned THIN_RCP_SHIFT  = 36;
  localparam int unsigned THIN_N_W        = 27;
  localparam int unsigned THIN_RCP_W      = 27;

  localparam int unsigned N_RAW_W   = 30;
  localparam int unsigned DIST_SCALE = 20000;

  // Distance of a Q0.16 position from the cell center
  function automatic logic [POS_W-1:0] center_dist(logic [POS_W-1:0] p);
    center_dist = (p >= HALF_POS) ? (p - HALF_POS) : (HALF_POS - p);
  endfunction

  // Mix one channel: (bg*(1-fac) + fg*fac), rounded half up
  function automatic chan_t blend_chan(chan_t bg, chan_t fg, logic [FAC_W-1:0] fac);
    logic [33:0] acc;
    acc = 34'(bg) * 34'(ONE_Q16 - fac) + 34'(fg) * 34'(fac) + 34'(HALF_POS);
    blend_chan = acc[31:16];
  endfunction

  function automatic rgb_t blend_rgb(rgb_t bg, rgb_t fg, logic [FAC_W-1:0] fac);
    rgb_t res;
    res.r = blend_chan(bg.r, fg.r, fac);
    res.g = blend_chan(bg.g, fg.g, fac);
    res.b = blend_chan(bg.b, fg.b, fac);
    blend_rgb = res;
  endfunction

  // Q0.16 channel to byte, rounded half up, capped at 255
  function automatic logic [BYTE_W-1:0] to_byte(chan_t c);
    logic [24:0] acc;
    acc = 25'(c) * 25'd255 + 25'(HALF_POS);
    to_byte = (acc[24:16] > 9'd255) ? 8'hFF : acc[23:16];
  endfunction

endpackage

`default_nettype wire

### design/grid_cell_texel_generator.sv
// ----------------------------------------------------------------------------
// grid_cell_texel_generator: procedural grid-cell texture, one texel per clock
// Takes a texel coordinate and returns its RGB color. Nine register stages
// from the accepted coordinate word to the color word: the fixed multiply
// chain (scale, reciprocal divide, two squarings, two blends, byte rounding)
// sets that latency. A new coordinate is taken every clock; a stalled color
// output holds the pipeline only as far back as stages are full, so bubbles
// still fill. Configuration is written through cfg_write/cfg_index/cfg_data
// while the pipeline is empty and takes effect on the next coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_texel_generator import gctg_pkg::*; #(
  parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // coordinate words
  input  logic                     coord_valid,
  output logic                     coord_ready,
  input  logic [MAX_SIZE_LOG2-1:0] col_x,
  input  logic [MAX_SIZE_LOG2-1:0] row_y,
  // color words
  output logic                     color_valid,
  input  logic                     color_ready,
  output logic [BYTE_W-1:0]        red,
  output logic [BYTE_W-1:0]        green,
  output logic [BYTE_W-1:0]        blue
);

  logic [CFG_SIZE_W-1:0] size_log2;
  logic                  thin_strips_enable;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  logic [POS_W-1:0] d_thick;
  logic [POS_W-1:0] d_thin;
  logic             thick_on;
  logic             thin_on;
  logic [FAC_W-1:0] f_thick;
  logic [FAC_W-1:0] f_thin;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2          <= SIZE_LOG2_RST;
      thin_strips_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_LOG2:   size_log2          <= cfg_data[CFG_SIZE_W-1:0];
        REG_THIN_ENABLE: thin_strips_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || color_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= coord_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign coord_ready = en[0];
  assign color_valid = vld[NUM_STAGES-1];

  gctg_coord #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2)
  ) u_coord (
    .clk               (clk),
    .en                (en[STG_COORD +: COORD_STG_N]),
    .col_x             (col_x),
    .row_y             (row_y),
    .size_log2         (size_log2),
    .thin_strips_enable(thin_strips_enable),
    .d_thick           (d_thick),
    .d_thin            (d_thin),
    .thick_on          (thick_on),
    .thin_on           (thin_on)
  );

  gctg_factor #(
    .THIN(1'b0)
  ) u_factor_thick (
    .clk     (clk),
    .en      (en[STG_FACTOR +: FACTOR_STG_N]),
    .center_d(d_thick),
    .active  (thick_on),
    .fac     (f_thick)
  );

  gctg_factor #(
    .THIN(1'b1)
  ) u_factor_thin (
    .clk     (clk),
    .en      (en[STG_FACTOR +: FACTOR_STG_N]),
    .center_d(d_thin),
    .active  (thin_on),
    .fac     (f_thin)
  );

  gctg_shade u_shade (
    .clk    (clk),
    .en     (en[STG_SHADE +: SHADE_STG_N]),
    .f_thin (f_thin),
    .f_thick(f_thick),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

`ifndef NO_ASSERTIONS
  // An empty output stage lets the whole pipeline move
  a_drain_accepts: assert property (@(posedge clk) disable iff (rst)
    !color_valid |-> coord_ready)
    else $error("coordinate stalled with empty output stage");

  // Factors never exceed one after the clamp
  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    vld[STG_SHADE-1] |-> (f_thick <= ONE_Q16 && f_thin <= ONE_Q16))
    else $error("blend factor above one");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("color word valid right after reset");
`endif

endmodule

`default_nettype wire

### design/gctg_coord.sv
// ----------------------------------------------------------------------------
// gctg_coord: texel coordinate to cell-center distances
// Stage one wraps the coordinate and forms the thick and thin grid positions;
// stage two takes the Chebyshev distance of each from the cell center.
// ----------------------------------------------------------------------------
`default_nettype none

module gctg_coord import gctg_pkg::*; #(
  parameter int unsigned MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF
) (
  input  logic                     clk,
  input  logic [COORD_STG_N-1:0]   en,
  input  logic [MAX_SIZE_LOG2-1:0] col_x,
  input  logic [MAX_SIZE_LOG2-1:0] row_y,
  input  logic [CFG_SIZE_W-1:0]    size_log2,
  input  logic                     thin_strips_enable,
  output logic [POS_W-1:0]         d_thick,
  output logic [POS_W-1:0]         d_thin,
  output logic                     thick_on,
  output logic                     thin_on
);

  localparam int unsigned X_W = MAX_SIZE_LOG2;
  localparam logic [CFG_SIZE_W-1:0] S_MAX = CFG_SIZE_W'(MAX_SIZE_LOG2);

  logic [CFG_SIZE_W-1:0] s_eff;
  logic [X_W-1:0]        mask;
  logic [X_W-1:0]        x_w;
  logic [X_W-1:0]        y_w;
  logic [X_W+3:0]        x10;
  logic [X_W+3:0]        y10;
  logic [4:0]            sh;

  logic [POS_W-1:0] px;
  logic [POS_W-1:0] py;
  logic [POS_W-1:0] tx;
  logic [POS_W-1:0] ty;
  logic             thick_on0;
  logic             thin_on0;

  // Wrap the coordinate and scale to Q0.16
  always_comb begin
    s_eff = (size_log2 > S_MAX) ? S_MAX : size_log2;
    mask  = ~({X_W{1'b1}} << s_eff);
    x_w   = col_x & mask;
    y_w   = row_y & mask;
    x10   = ((X_W+4)'(x_w) << 3) + ((X_W+4)'(x_w) << 1);
    y10   = ((X_W+4)'(y_w) << 3) + ((X_W+4)'(y_w) << 1);
    sh    = 5'(POS_W) - 5'(s_eff);
  end

  // Stage one: positions and strip enables
  always_ff @(posedge clk) begin
    if (en[0]) begin
      px        <= POS_W'(x_w) << sh;
      py        <= POS_W'(y_w) << sh;
      tx        <= POS_W'(x10[X_W-1:0] & mask) << sh;
      ty        <= POS_W'(y10[X_W-1:0] & mask) << sh;
      thick_on0 <= (s_eff >= THICK_MIN_LOG2);
      thin_on0  <= thin_strips_enable && (s_eff >= THIN_MIN_LOG2);
    end
  end

  // Stage two: Chebyshev distance from the center
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d_thick  <= (center_dist(px) > center_dist(py)) ? center_dist(px) : center_dist(py);
      d_thin   <= (center_dist(tx) > center_dist(ty)) ? center_dist(tx) : center_dist(ty);
      thick_on <= thick_on0;
      thin_on  <= thin_on0;
    end
  end

endmodule

`default_nettype wire

### design/gctg_factor.sv
// ----------------------------------------------------------------------------
// gctg_factor: strip blend factor from a cell-center distance
// Offset and scale, reciprocal divide by the falloff, clamp, then two
// squaring stages give the fourth power. Four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gctg_factor import gctg_pkg::*; #(
  parameter bit THIN = 1'b0
) (
  input  logic                    clk,
  input  logic [FACTOR_STG_N-1:0] en,
  input  logic [POS_W-1:0]        center_d,
  input  logic                    active,
  output logic [FAC_W-1:0]        fac
);

  localparam int unsigned N_W       = THIN ? THIN_N_W : THICK_N_W;
  localparam int unsigned RCP_W     = THIN ? THIN_RCP_W : THICK_RCP_W;
  localparam int unsigned RCP_SHIFT = THIN ? THIN_RCP_SHIFT : THICK_RCP_SHIFT;
  localparam int unsigned P_W       = N_W + RCP_W;
  localparam int unsigned Q_W       = P_W - RCP_SHIFT;

  localparam logic [POS_W-1:0]   D_MIN = POS_W'(THIN ? THIN_D_MIN : THICK_D_MIN);
  localparam logic [N_RAW_W-1:0] N_OFF = N_RAW_W'(THIN ? THIN_N_OFF : THICK_N_OFF);
  localparam logic [RCP_W-1:0]   RCP   = RCP_W'(THIN ? THIN_RCP : THICK_RCP);

  logic [N_RAW_W-1:0] n_raw;
  logic [N_W-1:0]     num;
  logic [P_W-1:0]     prod;
  logic [Q_W-1:0]     quo;
  logic [FAC_W-1:0]   t_clamp;
  logic [33:0]        t_sq;
  logic [FAC_W-1:0]   t2;
  logic [33:0]        t2_sq;

  always_comb begin
    n_raw   = N_RAW_W'(center_d) * N_RAW_W'(DIST_SCALE) - N_OFF;
    quo     = prod[P_W-1:RCP_SHIFT];
    t_clamp = (quo > Q_W'(ONE_Q16)) ? ONE_Q16 : quo[FAC_W-1:0];
    t_sq    = 34'(t_clamp) * 34'(t_clamp) + 34'(HALF_POS);
    t2_sq   = 34'(t2) * 34'(t2) + 34'(HALF_POS);
  end

  // Offset the distance; drop to zero inside the cell or when the strip is off
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num <= (active && (center_d >= D_MIN)) ? n_raw[N_W-1:0] : '0;
    end
  end

  // Divide by the falloff through the reciprocal
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod <= P_W'(num) * P_W'(RCP);
    end
  end

  // Clamp and square
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2 <= t_sq[32:16];
    end
  end

  // Square again for the fourth power
  always_ff @(posedge clk) begin
    if (en[3]) begin
      fac <= t2_sq[32:16];
    end
  end

endmodule

`default_nettype wire

### design/gctg_shade.sv
// ----------------------------------------------------------------------------
// gctg_shade: color blending and byte conversion
// Blend the thin grid over the background, the thick border over that,
// then round each channel to a byte. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gctg_shade import gctg_pkg::*; (
  input  logic                   clk,
  input  logic [SHADE_STG_N-1:0] en,
  input  logic [FAC_W-1:0]       f_thin,
  input  logic [FAC_W-1:0]       f_thick,
  output logic [BYTE_W-1:0]      red,
  output logic [BYTE_W-1:0]      green,
  output logic [BYTE_W-1:0]      blue
);

  rgb_t             mid;
  rgb_t             lit;
  logic [FAC_W-1:0] f_thick_d;

  // Thin grid over background; carry the thick factor along
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mid       <= blend_rgb(BG_COLOR, THIN_COLOR, f_thin);
      f_thick_d <= f_thick;
    end
  end

  // Thick border on top
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lit <= blend_rgb(mid, THICK_COLOR, f_thick_d);
    end
  end

  // Round to bytes
  always_ff @(posedge clk) begin
    if (en[2]) begin
      red   <= to_byte(lit.r);
      green <= to_byte(lit.g);
      blue  <= to_byte(lit.b);
    end
  end

endmodule

`default_nettype wire
